### design/uks_pkg.sv
// shared types and constants of the unique key stack
package uks_pkg;

  localparam int unsigned StackDepthDef = 16;
  localparam int unsigned DataW         = 32;
  localparam int unsigned ActionW       = 2;
  localparam int unsigned StatusW       = 2;
  localparam int unsigned CountW        = 5;

  typedef enum logic [ActionW-1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_UNDER = 2'd2,
    ST_OVER  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_e;

endpackage

### design/uks_if.sv
// item channels of the unique key stack
interface uks_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                action;
  logic signed [31:0]        entry_key;
  logic signed [31:0]        entry_value;

  modport source (output valid, action, entry_key, entry_value, input ready);
  modport sink   (input valid, action, entry_key, entry_value, output ready);
endinterface

interface uks_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic signed [31:0]        top_key;
  logic signed [31:0]        top_value;
  logic [4:0]                held_count;
  logic                      is_empty;

  modport source (output valid, status, top_key, top_value, held_count, is_empty,
                  input ready);
  modport sink   (input valid, status, top_key, top_value, held_count, is_empty,
                  output ready);
endinterface

### design/uks_store.sv
// key and value memory with one write port and one registered read port
module uks_store #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [uks_pkg::DataW-1:0] wkey_i,
  input  logic [uks_pkg::DataW-1:0] wval_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [uks_pkg::DataW-1:0] rkey_o,
  output logic [uks_pkg::DataW-1:0] rval_o
);
  import uks_pkg::*;

  logic [DataW-1:0] key_mem [Depth];
  logic [DataW-1:0] val_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i] <= wkey_i;
      val_mem[waddr_i] <= wval_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rkey_o <= key_mem[raddr_i];
      rval_o <= val_mem[raddr_i];
    end
  end

endmodule

### design/unique_key_stack.sv
// top level of the unique key stack
//
//  channel  dir  handshake      payload
//  in_i     in   valid / ready  action, entry_key, entry_value
//  out_o    out  valid / ready  status, top_key, top_value, held_count, is_empty
//
// push does one memory read per held entry for the key search
// a push onto an empty stack skips the search
// pop, peek and the unused action skip the search (pop and peek read the top entry)
// one item at a time; a result waits in the output register, the next item is
// taken meanwhile and holds in its last cycle until that register is free
// reset clears the fill level and the control; the memory needs no clearing
module unique_key_stack #(
  parameter int unsigned STACK_DEPTH = uks_pkg::StackDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  uks_in_if.sink    in_i,
  uks_out_if.source out_o
);
  import uks_pkg::*;

  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(STACK_DEPTH + 1);

  state_e             state_q, state_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [FillW-1:0]   cnt_q, cnt_d;
  logic               hit_q, hit_d;
  logic               pend_q, pend_d;
  logic [ActionW-1:0] act_q, act_d;
  logic [DataW-1:0]   key_q, key_d;
  logic [DataW-1:0]   val_q, val_d;

  logic               out_vld_q, out_vld_d;
  logic [StatusW-1:0] out_status_q, out_status_d;
  logic [DataW-1:0]   out_key_q, out_key_d;
  logic [DataW-1:0]   out_val_q, out_val_d;
  logic [CountW-1:0]  out_count_q, out_count_d;
  logic               out_empty_q, out_empty_d;

  logic               in_fire, done_fire, full;
  logic               re, we;
  logic [AddrW-1:0]   raddr;
  logic [DataW-1:0]   rkey, rval;
  logic [FillW-1:0]   fill_res;
  logic [FillW-1:0]   fill_top;
  logic [FillW+CountW-1:0] fill_ext;
  status_e            status;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign done_fire  = (state_q == S_DONE) && (!out_vld_q || out_o.ready);
  assign full       = (fill_q == FillW'(STACK_DEPTH));
  assign fill_top   = fill_q - FillW'(1);

  uks_store #(
    .Depth (STACK_DEPTH),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (fill_q[AddrW-1:0]),
    .wkey_i  (key_q),
    .wval_i  (val_q),
    .re_i    (re),
    .raddr_i (raddr),
    .rkey_o  (rkey),
    .rval_o  (rval)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if ((in_i.action == ACT_PUSH) && (fill_q != '0)) state_d = S_SEARCH;
          else state_d = S_DONE;
        end
      end
      S_SEARCH: begin
        if (cnt_q == fill_q) state_d = S_DONE;
      end
      S_DONE: begin
        if (done_fire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    act_d        = act_q;
    key_d        = key_q;
    val_d        = val_q;
    cnt_d        = cnt_q;
    hit_d        = hit_q;
    pend_d       = 1'b0;
    fill_d       = fill_q;
    re           = 1'b0;
    raddr        = cnt_q[AddrW-1:0];
    we           = 1'b0;
    status       = ST_OK;
    fill_res     = fill_q;
    out_vld_d    = out_vld_q && !out_o.ready;
    out_status_d = out_status_q;
    out_key_d    = out_key_q;
    out_val_d    = out_val_q;
    out_count_d  = out_count_q;
    out_empty_d  = out_empty_q;
    fill_ext     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          act_d = in_i.action;
          key_d = in_i.entry_key;
          val_d = in_i.entry_value;
          cnt_d = '0;
          hit_d = 1'b0;
          if (((in_i.action == ACT_POP) || (in_i.action == ACT_PEEK)) && (fill_q != '0)) begin
            re    = 1'b1;
            raddr = fill_top[AddrW-1:0];
          end
        end
      end
      S_SEARCH: begin
        if (cnt_q != fill_q) begin
          re     = 1'b1;
          cnt_d  = cnt_q + FillW'(1);
          pend_d = 1'b1;
        end
        if (pend_q && (rkey == key_q)) hit_d = 1'b1;
      end
      S_DONE: begin
        out_key_d = '0;
        out_val_d = '0;
        unique case (act_q)
          ACT_PUSH: begin
            if (hit_q) status = ST_DUP;
            else if (full) status = ST_OVER;
            else begin
              we       = done_fire;
              fill_res = fill_q + FillW'(1);
            end
          end
          ACT_POP, ACT_PEEK: begin
            if (fill_q == '0) status = ST_UNDER;
            else begin
              out_key_d = rkey;
              out_val_d = rval;
              if (act_q == ACT_POP) fill_res = fill_top;
            end
          end
          default: status = ST_OK;
        endcase
        fill_ext = {{CountW{1'b0}}, fill_res};
        if (done_fire) begin
          out_vld_d    = 1'b1;
          out_status_d = status;
          out_count_d  = fill_ext[CountW-1:0];
          out_empty_d  = (fill_res == '0);
          fill_d       = fill_res;
        end else begin
          out_key_d = out_key_q;
          out_val_d = out_val_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      cnt_q     <= '0;
      hit_q     <= 1'b0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      cnt_q     <= cnt_d;
      hit_q     <= hit_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    key_q        <= key_d;
    val_q        <= val_d;
    out_status_q <= out_status_d;
    out_key_q    <= out_key_d;
    out_val_q    <= out_val_d;
    out_count_q  <= out_count_d;
    out_empty_q  <= out_empty_d;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.status     = out_status_q;
  assign out_o.top_key    = out_key_q;
  assign out_o.top_value  = out_val_q;
  assign out_o.held_count = out_count_q;
  assign out_o.is_empty   = out_empty_q;

  // fill level never exceeds the depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(STACK_DEPTH))
    else $error("fill level above depth");

  // the search never reads beyond the held entries
  a_search_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH && re) |-> (cnt_q < fill_q))
    else $error("search read beyond fill level");

  // a rejected or failed action leaves the fill level alone
  a_reject_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_fire && status != ST_OK) |=> $stable(fill_q))
    else $error("fill level changed on rejected item");

  // underflow results carry zero data
  a_under_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_status_q == ST_UNDER) |-> (out_key_q == '0 && out_val_q == '0))
    else $error("underflow result with data");

endmodule
